### rtl/fir_lp_pkg.sv
// Shared constants, coefficient table and types for the 161-tap lowpass filter.
package fir_lp_pkg;

    localparam int TAPS     = 161;
    localparam int HIST_LEN = TAPS - 1;
    localparam int ROM_LEN  = 161;
    localparam int ADDR_W   = (HIST_LEN > 1) ? $clog2(HIST_LEN) : 1;
    localparam int TAP_W    = $clog2(TAPS);
    localparam int FILL_W   = $clog2(HIST_LEN + 1);
    localparam int ROM_AW   = $clog2(ROM_LEN);
    localparam int SMP_W    = 16;
    localparam int COEF_W   = 16;
    localparam int PROD_W   = SMP_W + COEF_W;
    localparam int ACC_W    = 32;
    localparam int OUT_SHIFT = 15;

    localparam logic signed [ACC_W-1:0] SAT_HI = 32'sh3fff_ffff;
    localparam logic signed [ACC_W-1:0] SAT_LO = -32'sh4000_0000;

    localparam logic signed [COEF_W-1:0] COEF_ROM [ROM_LEN] = '{
        16'sd120, 16'sd124, 16'sd126, 16'sd127, 16'sd127, 16'sd125, 16'sd122, 16'sd118,
        16'sd113, 16'sd106, 16'sd97, 16'sd88, 16'sd77, 16'sd65, 16'sd52, 16'sd38,
        16'sd24, 16'sd8, -16'sd8, -16'sd25, -16'sd42, -16'sd59, -16'sd76, -16'sd93,
        -16'sd110, -16'sd126, -16'sd142, -16'sd156, -16'sd170, -16'sd183, -16'sd194,
        -16'sd203, -16'sd211, -16'sd217, -16'sd221, -16'sd223, -16'sd223, -16'sd220,
        -16'sd215, -16'sd208, -16'sd198, -16'sd185, -16'sd170, -16'sd152, -16'sd132,
        -16'sd108, -16'sd83, -16'sd55, -16'sd24, 16'sd8, 16'sd43, 16'sd80, 16'sd119,
        16'sd159, 16'sd201, 16'sd244, 16'sd288, 16'sd333, 16'sd378, 16'sd424, 16'sd470,
        16'sd516, 16'sd561, 16'sd606, 16'sd650, 16'sd693, 16'sd734, 16'sd773, 16'sd811,
        16'sd847, 16'sd880, 16'sd911, 16'sd939, 16'sd964, 16'sd986, 16'sd1005, 16'sd1020,
        16'sd1033, 16'sd1041, 16'sd1047, 16'sd1049, 16'sd1047, 16'sd1041, 16'sd1033,
        16'sd1020, 16'sd1005, 16'sd986, 16'sd964, 16'sd939, 16'sd911, 16'sd880, 16'sd847,
        16'sd811, 16'sd773, 16'sd734, 16'sd693, 16'sd650, 16'sd606, 16'sd561, 16'sd516,
        16'sd470, 16'sd424, 16'sd378, 16'sd333, 16'sd288, 16'sd244, 16'sd201, 16'sd159,
        16'sd119, 16'sd80, 16'sd43, 16'sd8, -16'sd24, -16'sd55, -16'sd83, -16'sd108,
        -16'sd132, -16'sd152, -16'sd170, -16'sd185, -16'sd198, -16'sd208, -16'sd215,
        -16'sd220, -16'sd223, -16'sd223, -16'sd221, -16'sd217, -16'sd211, -16'sd203,
        -16'sd194, -16'sd183, -16'sd170, -16'sd156, -16'sd142, -16'sd126, -16'sd110,
        -16'sd93, -16'sd76, -16'sd59, -16'sd42, -16'sd25, -16'sd8, 16'sd8, 16'sd24,
        16'sd38, 16'sd52, 16'sd65, 16'sd77, 16'sd88, 16'sd97, 16'sd106, 16'sd113,
        16'sd118, 16'sd122, 16'sd125, 16'sd127, 16'sd127, 16'sd126, 16'sd124, 16'sd120
    };

    // Taps beyond the end of the table carry a zero coefficient.
    function automatic logic signed [COEF_W-1:0] coef_at(input logic [TAP_W-1:0] k);
        logic signed [COEF_W-1:0] c;
        c = '0;
        if (int'(k) < ROM_LEN)
        begin
            c = COEF_ROM[ROM_AW'(k)];
        end
        return c;
    endfunction

    // Command from the sequencer to the multiply-accumulate unit.
    typedef struct packed {
        logic                     clear;
        logic                     valid;
        logic signed [COEF_W-1:0] coef;
        logic signed [SMP_W-1:0]  operand;
    } mac_cmd_t;

endpackage

### rtl/fir_lp_hist_ram.sv
// Simple dual-port synchronous RAM holding the sample history.
module fir_lp_hist_ram #(
    parameter int DEPTH = 160,
    parameter int WIDTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/fir_lp_mac.sv
// Registered multiply followed by a 32-bit accumulator with output saturation.
module fir_lp_mac
    import fir_lp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  mac_cmd_t             cmd,
    output logic                 busy,
    output logic [SMP_W-1:0]     result
);

    logic                     p_valid_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid)
        begin
            prod_reg <= cmd.coef * cmd.operand;
        end
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.clear)
        begin
            acc_next = '0;
        end
        else if (p_valid_reg)
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    // Clamp to the range that survives the shift, then take the upper bits.
    always_comb
    begin
        if (acc_reg > SAT_HI)
        begin
            sat = SAT_HI;
        end
        else if (acc_reg < SAT_LO)
        begin
            sat = SAT_LO;
        end
        else
        begin
            sat = acc_reg;
        end
    end

    assign result = sat[OUT_SHIFT+SMP_W-1:OUT_SHIFT];
    assign busy   = p_valid_reg;

endmodule

### rtl/fir_lowpass_161_tap.sv
// Top level of the 161-tap lowpass FIR filter with saturating Q15 output.
//
// Usage: each word accepted on the s_axis channel is one signed 16-bit sample;
// for each one the filter delivers exactly one signed 16-bit word on m_axis.
// The output is the sum of the newest sample and the 160 previous ones, each
// weighted by the fixed lowpass coefficient table, clamped to -2^30..2^30-1
// and shifted arithmetically right by 15.
//
// The 160 past samples live in a ring in a synchronous RAM. One shared
// multiplier walks the taps, one tap per cycle, reading the RAM as it goes,
// so each item passes through these steps in order: it is accepted, the taps
// are issued, the read, multiply and accumulate stages drain, and the new
// sample is written back while the output register loads. The result appears
// on m_axis in the same cycle that the next word can be taken. The block takes
// no new word until it has written back the sample of the last one.
//
// After reset the history reads as zero: a fill count marks which ring entries
// hold real samples, so no clearing pass is needed and a word may be taken at
// once. The output sits in a register; while the receiver stalls the block
// still accepts and filters the next word, and only holds back its write-back
// until the waiting result has been taken.
module fir_lowpass_161_tap
    import fir_lp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [15:0]      s_axis_tdata,   // [15:0] sample
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [15:0]      m_axis_tdata    // [15:0] filtered_sample
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]              state_reg, state_next;
    logic [TAP_W-1:0]        tap_reg, tap_next;
    logic [ADDR_W-1:0]       ptr_reg, ptr_next;
    logic [ADDR_W-1:0]       rd_addr_reg, rd_addr_next;
    logic [FILL_W-1:0]       fill_reg, fill_next;
    logic signed [SMP_W-1:0] x_reg;

    // Read stage: what the tap issued last cycle needs alongside the RAM data.
    logic                     s1_valid_reg;
    logic                     s1_is_x_reg;
    logic                     s1_hit_reg;
    logic signed [COEF_W-1:0] s1_coef_reg;

    logic                    out_valid_reg;
    logic [SMP_W-1:0]        out_data_reg;

    logic                    accept;
    logic                    issue;
    logic                    rd_en;
    logic                    wr_en;
    logic                    out_free;
    logic [SMP_W-1:0]        rd_data;
    logic                    mac_busy;
    logic [SMP_W-1:0]        mac_result;
    mac_cmd_t                cmd;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign issue         = (state_reg == ST_ISSUE);
    assign rd_en         = issue && (tap_reg != '0);
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign wr_en         = (state_reg == ST_DONE) && out_free;

    always_comb
    begin
        state_next   = state_reg;
        tap_next     = tap_reg;
        ptr_next     = ptr_reg;
        rd_addr_next = rd_addr_reg;
        fill_next    = fill_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next   = ST_ISSUE;
                    tap_next     = '0;
                    rd_addr_next = (ptr_reg == '0) ? ADDR_W'(HIST_LEN - 1) : ptr_reg - 1'b1;
                end
            end
            ST_ISSUE:
            begin
                if (rd_en)
                begin
                    rd_addr_next = (rd_addr_reg == '0) ? ADDR_W'(HIST_LEN - 1)
                                                       : rd_addr_reg - 1'b1;
                end
                if (tap_reg == TAP_W'(TAPS - 1))
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    tap_next = tap_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (!s1_valid_reg && !mac_busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                    ptr_next   = (ptr_reg == ADDR_W'(HIST_LEN - 1)) ? '0 : ptr_reg + 1'b1;
                    if (fill_reg != FILL_W'(HIST_LEN))
                    begin
                        fill_next = fill_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            tap_reg      <= '0;
            ptr_reg      <= '0;
            rd_addr_reg  <= '0;
            fill_reg     <= '0;
            s1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            tap_reg      <= tap_next;
            ptr_reg      <= ptr_next;
            rd_addr_reg  <= rd_addr_next;
            fill_reg     <= fill_next;
            s1_valid_reg <= issue;
            if (wr_en)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg <= s_axis_tdata;
        end
        if (issue)
        begin
            s1_is_x_reg <= (tap_reg == '0);
            s1_hit_reg  <= FILL_W'(rd_addr_reg) < fill_reg;
            s1_coef_reg <= coef_at(tap_reg);
        end
        if (wr_en)
        begin
            out_data_reg <= mac_result;
        end
    end

    // Entries beyond the fill count have never been written and read as zero.
    always_comb
    begin
        cmd.clear = accept;
        cmd.valid = s1_valid_reg;
        cmd.coef  = s1_coef_reg;
        if (s1_is_x_reg)
        begin
            cmd.operand = x_reg;
        end
        else if (s1_hit_reg)
        begin
            cmd.operand = rd_data;
        end
        else
        begin
            cmd.operand = '0;
        end
    end

    // The oldest entry is read on the last tap before this write replaces it.
    fir_lp_hist_ram #(
        .DEPTH (HIST_LEN),
        .WIDTH (SMP_W),
        .AW    (ADDR_W)
    ) u_hist (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (ptr_reg),
        .wr_data (x_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr_reg),
        .rd_data (rd_data)
    );

    fir_lp_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .busy   (mac_busy),
        .result (mac_result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> (!s1_valid_reg && !mac_busy))
        else $error("pipeline not empty while idle");

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (int'(ptr_reg) < HIST_LEN) && (int'(fill_reg) <= HIST_LEN))
        else $error("ring pointer or fill count out of range");

    a_tap_range: assert property (@(posedge clk) disable iff (!rst_n)
        issue |-> (int'(tap_reg) < TAPS))
        else $error("tap index out of range");

    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> (m_axis_tvalid && s_axis_tready))
        else $error("write-back not followed by a result word");

    a_fill_follows_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (int'(fill_reg) < HIST_LEN) |-> (FILL_W'(ptr_reg) == fill_reg))
        else $error("fill count and ring pointer disagree before wrap");

endmodule
